// ===== hdl/tcc_pkg.sv =====
// tcc_pkg: shared types and constants for the text console cursor and scroll engine
// no dependencies; used by text_console_cursor_and_scroll
package tcc_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int CELL_COUNT = 2000;
  localparam int TAB_STEP   = 4;
  localparam int ROWS       = CELL_COUNT / COLUMNS;
  localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int CNT_W  = $clog2(CELL_COUNT + 1);
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // request kinds
  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] RESET_COLOR = 8'h2F;

  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  ROW_PAST  = ROW_W'(ROWS);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);

endpackage

// ===== hdl/text_console_cursor_and_scroll.sv =====
// a put or no-op goes through the done state into the output register, a read through
// the read state and then the done state; a put that scrolls first sweeps the cell ram,
// copying each row up and blanking the bottom row, and a clear first blanks every cell;
// a full output register adds its wait. one item at a time: a new request is taken only
// in the idle state. after reset a clearing pass writes zero to all CELL_COUNT (2000) cells,
// inputs are held off meanwhile; config is always taken.
// text_console_cursor_and_scroll: top level, uses tcc_pkg and tcc_ram
module text_console_cursor_and_scroll (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcc_pkg::CHAR_W-1:0]        cfg_data_i,    // print_color
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [tcc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // char_code[7:0], read_addr[18:8]
  input  logic [1:0]                        s_axis_tuser,  // req_type[1:0]
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tcc_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // cursor_col[6:0], cursor_row[11:7],
                                                           // cell_data[27:12], did_scroll[28]
);

  localparam int AW  = tcc_pkg::ADDR_W;
  localparam int CW  = tcc_pkg::COL_W;
  localparam int RW  = tcc_pkg::ROW_W;
  localparam int NW  = tcc_pkg::CNT_W;
  localparam int DW  = tcc_pkg::CELL_W;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR,
    ST_DONE
  } state_e;

  state_e                     state_q;
  logic [NW-1:0]              cnt_q;
  logic [CW-1:0]              col_q;
  logic [RW-1:0]              row_q;
  logic [AW-1:0]              off_q;
  logic [tcc_pkg::CHAR_W-1:0] color_q;
  logic [DW-1:0]              res_cell_q;
  logic                       res_scroll_q;
  logic                       out_valid_q;
  logic [tcc_pkg::OUT_DATA_W-1:0] out_data_q;

  // input fields
  tcc_pkg::req_e              req;
  logic [tcc_pkg::CHAR_W-1:0] char_code;
  logic [AW-1:0]              read_addr;
  logic                       in_fire;

  assign req       = tcc_pkg::req_e'(s_axis_tuser);
  assign char_code = s_axis_tdata[7:0];
  assign read_addr = s_axis_tdata[18:8];
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  logic [DW-1:0] blank;
  assign blank = {color_q, tcc_pkg::CH_SPACE};

  // cursor update for a put request
  logic [CW-1:0] n_col;
  logic [RW-1:0] n_row;
  logic [AW-1:0] n_off;
  logic          put_wr;
  logic [AW-1:0] put_addr;
  logic [DW-1:0] put_data;
  logic          put_scroll;
  logic [CW:0]   tab_sum;

  always_comb begin
    n_col      = col_q;
    n_row      = row_q;
    n_off      = off_q;
    put_wr     = 1'b0;
    put_addr   = off_q;
    put_data   = {color_q, char_code};
    put_scroll = 1'b0;
    tab_sum    = {1'b0, col_q} + (CW+1)'(tcc_pkg::TAB_STEP);
    unique case (char_code)
      tcc_pkg::CH_LF: begin
        n_col = '0;
        n_row = row_q + 1'b1;
        n_off = off_q - AW'(col_q) + AW'(tcc_pkg::COLUMNS);
      end
      tcc_pkg::CH_CR: begin
        n_col = '0;
        n_off = off_q - AW'(col_q);
      end
      tcc_pkg::CH_TAB: begin
        if (tab_sum >= (CW+1)'(tcc_pkg::COLUMNS)) begin
          n_col = CW'(tab_sum - (CW+1)'(tcc_pkg::COLUMNS));
          n_row = row_q + 1'b1;
        end else begin
          n_col = CW'(tab_sum);
        end
        n_off = off_q + AW'(tcc_pkg::TAB_STEP);
      end
      tcc_pkg::CH_BS: begin
        // at the home cell the cursor stays and the cell is blanked
        if (off_q != '0) begin
          if (col_q == '0) begin
            n_col = tcc_pkg::COL_LAST;
            n_row = row_q - 1'b1;
          end else begin
            n_col = col_q - 1'b1;
          end
          n_off = off_q - 1'b1;
        end
        put_wr   = 1'b1;
        put_addr = n_off;
        put_data = blank;
      end
      default: begin
        put_wr = 1'b1;
        if (col_q == tcc_pkg::COL_LAST) begin
          n_col = '0;
          n_row = row_q + 1'b1;
        end else begin
          n_col = col_q + 1'b1;
        end
        n_off = off_q + 1'b1;
      end
    endcase
    // past the last row: scroll and pull the cursor back one row
    if (n_row == tcc_pkg::ROW_PAST) begin
      put_scroll = 1'b1;
      n_row      = tcc_pkg::ROW_LAST;
      n_off      = n_off - AW'(tcc_pkg::COLUMNS);
    end
  end

  // cell ram control
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic [NW-1:0] cnt_prev;
  logic          read_ok;

  assign cnt_prev = cnt_q - 1'b1;
  assign read_ok  = (read_addr <= tcc_pkg::CELL_LAST);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = blank;
    rd_en   = 1'b0;
    rd_addr = read_addr;
    unique case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      ST_IDLE: begin
        if (in_fire && req == tcc_pkg::REQ_PUT) begin
          wr_en   = put_wr;
          wr_addr = put_addr;
          wr_data = put_data;
        end
        if (in_fire && req == tcc_pkg::REQ_READ && read_ok) begin
          rd_en = 1'b1;
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the word back one row up, then blank the bottom row
        rd_en   = (cnt_q < NW'(tcc_pkg::COPY_COUNT));
        rd_addr = AW'(cnt_q + NW'(tcc_pkg::COLUMNS));
        wr_en   = (cnt_q != '0);
        wr_addr = cnt_prev[AW-1:0];
        wr_data = (cnt_prev < NW'(tcc_pkg::COPY_COUNT)) ? rd_data : blank;
      end
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  tcc_ram #(
    .WIDTH (DW),
    .DEPTH (tcc_pkg::CELL_COUNT)
  ) u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer, cursor and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      off_q        <= '0;
      color_q      <= tcc_pkg::RESET_COLOR;
      res_cell_q   <= '0;
      res_scroll_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      // the done state reloads the output register itself
      if (out_valid_q && m_axis_tready && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_INIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NW'(tcc_pkg::CELL_COUNT - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            res_cell_q   <= '0;
            res_scroll_q <= 1'b0;
            cnt_q        <= '0;
            case (req)
              tcc_pkg::REQ_PUT: begin
                col_q        <= n_col;
                row_q        <= n_row;
                off_q        <= n_off;
                res_scroll_q <= put_scroll;
                state_q      <= put_scroll ? ST_SCROLL : ST_DONE;
              end
              tcc_pkg::REQ_CLEAR: begin
                col_q   <= '0;
                row_q   <= '0;
                off_q   <= '0;
                state_q <= ST_CLEAR;
              end
              tcc_pkg::REQ_READ: begin
                state_q <= read_ok ? ST_READ : ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          res_cell_q <= rd_data;
          state_q    <= ST_DONE;
        end
        ST_SCROLL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NW'(tcc_pkg::CELL_COUNT)) begin
            state_q <= ST_DONE;
          end
        end
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == NW'(tcc_pkg::CELL_COUNT - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hand the result over once the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, res_scroll_q, res_cell_q, row_q, col_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // cursor stays on screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= tcc_pkg::COL_LAST) && (row_q <= tcc_pkg::ROW_LAST))
    else $error("cursor left the screen");

  // linear offset tracks row and column
  a_offset_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(off_q) == int'(row_q) * tcc_pkg::COLUMNS + int'(col_q))
    else $error("cursor offset out of step with row and column");

  // the cell ram is never read at the cell it writes in the same cycle, in the sweep or elsewhere
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("read and write of the same cell in one cycle");

endmodule

// ===== hdl/tcc_ram.sv =====
// tcc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
